FILE: rtl/sre_pkg.sv
// Shared types, constants and register codes for the signature record extractor.
`timescale 1ns / 1ps

package sre_pkg;

    localparam int MAX_RECORD_WORDS_DEF = 512;

    localparam int SIG_W    = 64;
    localparam int OFFS_W   = 9;
    localparam int LEN_W    = 10;
    localparam int WADDR_W  = 37;
    localparam int BADDR_W  = 40;
    localparam int ID_W     = 32;
    localparam int WORD_W   = 64;
    localparam int CIDX_W   = 3;

    localparam logic [SIG_W-1:0]  SIGNATURE_RST = 64'h0000_0000_00B6_0003;
    localparam logic [OFFS_W-1:0] ID_OFFS_RST     = 9'd92;
    localparam logic [OFFS_W-1:0] PARENT_OFFS_RST = 9'd124;
    localparam logic [OFFS_W-1:0] LABEL_OFFS_RST  = 9'd138;
    localparam logic [LEN_W-1:0]  REC_LEN_RST     = 10'd259;

    typedef enum logic [CIDX_W-1:0] {
        REG_SIGNATURE  = 3'd0,
        REG_ID_OFFS    = 3'd1,
        REG_PARENT_OFFS = 3'd2,
        REG_LABEL_OFFS = 3'd3,
        REG_REC_LEN    = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic [SIG_W-1:0]  signature_word;
        logic [OFFS_W-1:0] id_word_offset;
        logic [OFFS_W-1:0] parent_word_offset;
        logic [OFFS_W-1:0] label_word_offset;
        logic [LEN_W-1:0]  record_length_words;
    } cfg_t;

    typedef struct packed {
        logic               valid;
        logic [BADDR_W-1:0] record_address;
        logic [ID_W-1:0]    record_id;
        logic [ID_W-1:0]    parent_id;
        logic [WORD_W-1:0]  label_low;
        logic [WORD_W-1:0]  label_high;
    } result_t;

endpackage

FILE: rtl/signature_record_extractor_core.sv
// A result is formed by the scanner from the word in the input register and is held in the output register.
// Throughput: one word per cycle while the output is not stalled; each word takes one step of the scanner
// (a 64-bit signature compare plus the record word counter) between input and output registers.
// An untaken result holds the scanner; the input register then keeps at most one waiting word.
// Reset: asynchronous, active low; clears the scan state and counters and loads the
// configuration registers with their default values.
`timescale 1ns / 1ps

module signature_record_extractor_core
    import sre_pkg::*;
#(
    parameter int MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [WORD_W-1:0]  data_word,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [BADDR_W-1:0] record_address,
    output logic [ID_W-1:0]    record_id,
    output logic [ID_W-1:0]    parent_id,
    output logic [WORD_W-1:0]  label_low,
    output logic [WORD_W-1:0]  label_high,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [SIG_W-1:0]   cfg_data
);

    cfg_t    cfg;
    result_t res;

    logic              in_valid_reg, in_valid_next;
    logic [WORD_W-1:0] in_word_reg,  in_word_next;
    result_t           out_reg,      out_next;
    logic              out_valid_reg, out_valid_next;
    logic              step;

    assign cfg_ready = 1'b1;

    sre_cfg_regs u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // Advance the input word when the output register is free or being drained.
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;

    sre_scanner #(
        .MAX_RECORD_WORDS (MAX_RECORD_WORDS)
    ) u_scan
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .word   (in_word_reg),
        .cfg    (cfg),
        .result (res)
    );

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_word_next  = in_word_reg;
        if (in_valid && in_ready)
        begin
            in_valid_next = 1'b1;
            in_word_next  = data_word;
        end
        else if (step)
        begin
            in_valid_next = 1'b0;
        end

        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (step)
        begin
            out_valid_next = res.valid;
            if (res.valid)
                out_next = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
        out_reg     <= out_next;
    end

    assign out_valid      = out_valid_reg;
    assign record_address = out_reg.record_address;
    assign record_id      = out_reg.record_id;
    assign parent_id      = out_reg.parent_id;
    assign label_low      = out_reg.label_low;
    assign label_high     = out_reg.label_high;

    a_result_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> step)
        else $error("scanner result without a word step");

    a_no_step_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |-> !step)
        else $error("word stepped while output register stalled");

    a_input_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !step) |=> (in_valid_reg && $stable(in_word_reg)))
        else $error("pending input word lost or changed");

endmodule

FILE: rtl/sre_cfg_regs.sv
// Configuration register bank for the signature record extractor.
`timescale 1ns / 1ps

module sre_cfg_regs
    import sre_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [CIDX_W-1:0] wr_index,
    input  logic [SIG_W-1:0]  wr_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_SIGNATURE:   cfg_next.signature_word      = wr_data;
                REG_ID_OFFS:     cfg_next.id_word_offset      = wr_data[OFFS_W-1:0];
                REG_PARENT_OFFS: cfg_next.parent_word_offset  = wr_data[OFFS_W-1:0];
                REG_LABEL_OFFS:  cfg_next.label_word_offset   = wr_data[OFFS_W-1:0];
                REG_REC_LEN:     cfg_next.record_length_words = wr_data[LEN_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.signature_word      <= SIGNATURE_RST;
            cfg_reg.id_word_offset      <= ID_OFFS_RST;
            cfg_reg.parent_word_offset  <= PARENT_OFFS_RST;
            cfg_reg.label_word_offset   <= LABEL_OFFS_RST;
            cfg_reg.record_length_words <= REC_LEN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/sre_scanner.sv
// Scan state, record word counter and field capture; one word per step.
`timescale 1ns / 1ps

module sre_scanner
    import sre_pkg::*;
#(
    parameter int MAX_RECORD_WORDS = MAX_RECORD_WORDS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [WORD_W-1:0] word,
    input  cfg_t              cfg,
    output result_t           result
);

    localparam int CNT_W = (MAX_RECORD_WORDS > 2) ? $clog2(MAX_RECORD_WORDS) : 1;
    localparam int CMP_W = ((CNT_W > LEN_W) ? CNT_W : LEN_W) + 1;
    localparam logic [CMP_W-1:0] MAX_LEN = CMP_W'(MAX_RECORD_WORDS);

    logic               inside_reg,    inside_next;
    logic [CNT_W-1:0]   wir_reg,       wir_next;
    logic [WADDR_W-1:0] waddr_reg,     waddr_next;
    logic [BADDR_W-1:0] match_addr_reg, match_addr_next;
    logic [ID_W-1:0]    held_id_reg,   held_id_next;
    logic [ID_W-1:0]    held_par_reg,  held_par_next;
    logic [WORD_W-1:0]  held_lab_reg,  held_lab_next;

    logic [CMP_W-1:0] len_raw;
    logic [CMP_W-1:0] len_eff;
    logic [CMP_W-1:0] pos;
    logic [CMP_W-1:0] label_pos2;

    always_comb
    begin
        len_raw = CMP_W'(cfg.record_length_words);
        if (len_raw == '0)
            len_eff = CMP_W'(1);
        else if (len_raw > MAX_LEN)
            len_eff = MAX_LEN;
        else
            len_eff = len_raw;
    end

    assign pos        = CMP_W'(wir_reg) + CMP_W'(1);
    assign label_pos2 = CMP_W'(cfg.label_word_offset) + CMP_W'(1);

    always_comb
    begin
        inside_next     = inside_reg;
        wir_next        = wir_reg;
        waddr_next      = waddr_reg;
        match_addr_next = match_addr_reg;
        held_id_next    = held_id_reg;
        held_par_next   = held_par_reg;
        held_lab_next   = held_lab_reg;
        result          = '0;

        if (step)
        begin
            waddr_next = waddr_reg + WADDR_W'(1);
            if (!inside_reg)
            begin
                if (word == cfg.signature_word)
                begin
                    match_addr_next = {waddr_reg, 3'b000};
                    held_id_next    = '0;
                    held_par_next   = '0;
                    held_lab_next   = '0;
                    wir_next        = '0;
                    inside_next     = (len_eff > CMP_W'(1));
                end
            end
            else
            begin
                if (pos == CMP_W'(cfg.id_word_offset))
                    held_id_next = word[ID_W-1:0];
                if (pos == CMP_W'(cfg.parent_word_offset))
                    held_par_next = word[ID_W-1:0];
                if (pos == CMP_W'(cfg.label_word_offset))
                    held_lab_next = word;
                // Second name word closes the result; id and parent may land here too.
                if (pos == label_pos2)
                begin
                    result.valid          = 1'b1;
                    result.record_address = match_addr_reg;
                    result.record_id      = held_id_next;
                    result.parent_id      = held_par_next;
                    result.label_low      = held_lab_reg;
                    result.label_high     = word;
                end
                if (pos + CMP_W'(1) >= len_eff)
                begin
                    inside_next = 1'b0;
                    wir_next    = '0;
                end
                else
                begin
                    wir_next = pos[CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg     <= 1'b0;
            wir_reg        <= '0;
            waddr_reg      <= '0;
            match_addr_reg <= '0;
            held_id_reg    <= '0;
            held_par_reg   <= '0;
            held_lab_reg   <= '0;
        end
        else
        begin
            inside_reg     <= inside_next;
            wir_reg        <= wir_next;
            waddr_reg      <= waddr_next;
            match_addr_reg <= match_addr_next;
            held_id_reg    <= held_id_next;
            held_par_reg   <= held_par_next;
            held_lab_reg   <= held_lab_next;
        end
    end

endmodule
